FILE: rtl/sgbi_pkg.sv
package sgbi_pkg;

   // Field widths of the request and response transactions
   localparam int COORD_W    = 25;
   localparam int INDEX_W    = 8;
   localparam int SAMPLE_W   = 32;
   localparam int CSR_W      = 9;
   localparam int CSR_IDX_W  = 1;

   localparam int REQ_DATA_W = 104;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1;

   // req_tdata bit offsets
   localparam int CX_LSB  = 0;
   localparam int CY_LSB  = CX_LSB + COORD_W;
   localparam int COL_LSB = CY_LSB + COORD_W;
   localparam int ROW_LSB = COL_LSB + INDEX_W;
   localparam int VAL_LSB = ROW_LSB + INDEX_W;

   // req_tuser bits
   localparam int FUNC_BIT = 0;
   localparam int COMP_BIT = 1;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;
   localparam logic COMP_X     = 1'b0;
   localparam logic COMP_Y     = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 1'b1;
   localparam logic [CSR_W-1:0]     GRID_SIZE_RESET = 9'd256;

   localparam logic [RSP_DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [RSP_DATA_W-1:0] SAT_MIN = 32'h8000_0000;

   typedef enum logic [1:0] {
      SRC_SAMPLE,
      SRC_ACC_LO,
      SRC_ACC_HI
   } sgbi_src_type;

   typedef enum logic [1:0] {
      ACC_A_HOLD,
      ACC_A_LOAD,
      ACC_A_ADD
   } sgbi_acc_a_type;

   typedef enum logic [1:0] {
      ACC_T_HOLD,
      ACC_T_INIT,
      ACC_T_ADD_LO,
      ACC_T_ADD_HI
   } sgbi_acc_t_type;

   typedef struct packed {
      logic           mul_en;
      sgbi_src_type   src;
      sgbi_acc_a_type a_op;
      sgbi_acc_t_type t_op;
   } sgbi_mac_ctrl_type;

endpackage

FILE: rtl/sgbi_mac.sv
module sgbi_mac import sgbi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  sgbi_mac_ctrl_type              ctrl,
   input  logic [FRAC_BITS:0]             weight,
   input  logic signed [SAMPLE_W-1:0]     sample,
   output logic signed [2*FRAC_BITS+33:0] acc_total
);

   localparam int OPW = SAMPLE_W + 1;
   localparam int PW  = FRAC_BITS + 35;
   localparam int AW  = FRAC_BITS + 33;
   localparam int TW  = 2 * FRAC_BITS + 34;

   // half an LSB of the final result, folded in up front
   localparam logic signed [TW-1:0] ROUND_INIT = TW'(1) <<< (2 * FRAC_BITS - 1);

   logic signed [OPW-1:0] op_b;
   logic signed [PW-1:0]  prod_in, prod_ff;
   logic signed [AW-1:0]  acc_a_in, acc_a_ff;
   logic signed [TW-1:0]  acc_t_in, acc_t_ff;
   logic signed [TW-1:0]  prod_ext;

   always_comb begin
      case (ctrl.src)
         SRC_SAMPLE: op_b = OPW'(sample);
         SRC_ACC_LO: op_b = $signed({1'b0, acc_a_ff[31:0]});
         SRC_ACC_HI: op_b = OPW'($signed(acc_a_ff[AW-1:32]));
         default:    op_b = '0;
      endcase
   end

   assign prod_in  = $signed({1'b0, weight}) * op_b;
   assign prod_ext = TW'(prod_ff);

   always_comb begin
      case (ctrl.a_op)
         ACC_A_LOAD: acc_a_in = AW'(prod_ff);
         ACC_A_ADD:  acc_a_in = acc_a_ff + AW'(prod_ff);
         default:    acc_a_in = acc_a_ff;
      endcase
   end

   // the row sum is split in two 32-bit halves; the upper half is weighted by 2^32
   always_comb begin
      case (ctrl.t_op)
         ACC_T_INIT:   acc_t_in = ROUND_INIT;
         ACC_T_ADD_LO: acc_t_in = acc_t_ff + prod_ext;
         ACC_T_ADD_HI: acc_t_in = acc_t_ff + (prod_ext <<< 32);
         default:      acc_t_in = acc_t_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_a_ff <= acc_a_in;
      acc_t_ff <= acc_t_in;
   end

   assign acc_total = acc_t_ff;

endmodule

FILE: rtl/staggered_grid_bilinear_interp.sv
// Write transaction: stored at the accepting edge, no response; next request in the following cycle.
// Query: ST_RD, ST_MULX, ST_ACCX per corner, ST_MYL, ST_AYL, ST_MYH, ST_AYH per row, ST_FIN;
// no new request until back in ST_IDLE. Four single-port reads, each through the one shared
// multiplier, plus two 32-bit halves per row for the y weighting. Out of range: straight to ST_FIN.
// A response not yet taken holds a finished query in its last state until the output frees.
// Sync active-high reset: sequencer, response valid cleared, grid sizes 256; samples kept.
module staggered_grid_bilinear_interp import sgbi_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // coord_x, coord_y, cell_col, cell_row, cell_value, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func, component
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // interp_value
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // out_of_range
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int CB    = $clog2(MAX_WIDTH);
   localparam int RB    = $clog2(MAX_HEIGHT);
   localparam int MAW   = 1 + RB + CB;
   localparam int DEPTH = 1 << MAW;
   localparam int WW    = FRAC_BITS + 1;
   localparam int KS    = COORD_W + 1;
   localparam int KW    = KS - FRAC_BITS;
   localparam int TW    = 2 * FRAC_BITS + 34;
   localparam int HW    = TW - 2 * FRAC_BITS;

   localparam logic [WW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [KS-1:0] HALF = KS'({1'b1, {(FRAC_BITS - 1){1'b0}}});

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_MULX,
      ST_ACCX,
      ST_MYL,
      ST_AYL,
      ST_MYH,
      ST_AYH,
      ST_FIN
   } state_type;

   state_type state_in, state_ff;
   logic [1:0] corner_in, corner_ff;
   logic rsp_valid_in, rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in, rsp_data_ff;
   logic rsp_oor_in, rsp_oor_ff;
   logic [CSR_W-1:0] width_ff, height_ff;

   // query context captured at acceptance
   logic comp_ff;
   logic oor_in, oor_ff;
   logic [WW-1:0] wx_in, wx_ff, wy_in, wy_ff;
   logic [CB-1:0] c0_in, c0_ff, c1_in, c1_ff;
   logic [RB-1:0] r0_in, r0_ff, r1_in, r1_ff;
   logic [3:0] zero_in, zero_ff;

   logic [SAMPLE_W-1:0] grid_ff [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [MAW-1:0] rd_addr, wr_addr;
   logic mem_we;

   logic accept, is_query;
   logic [COORD_W-1:0] cx, cy;
   logic [INDEX_W-1:0] wr_col, wr_row;
   logic [CSR_W-1:0] lx, ly;
   logic [KS-1:0] sx, sy;
   logic [KW-1:0] kx, ky;
   logic lowx, highx, lowy, highy;

   sgbi_mac_ctrl_type mac_ctrl;
   logic [WW-1:0] mac_weight;
   logic signed [SAMPLE_W-1:0] mac_sample;
   logic signed [TW-1:0] acc_total;
   logic signed [TW-1:0] res_full;
   logic [HW-32:0] res_hi;
   logic [RSP_DATA_W-1:0] res_sat;
   logic out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign is_query   = (req_tuser[FUNC_BIT] == FUNC_QUERY);
   assign cx         = req_tdata[CX_LSB +: COORD_W];
   assign cy         = req_tdata[CY_LSB +: COORD_W];
   assign wr_col     = req_tdata[COL_LSB +: INDEX_W];
   assign wr_row     = req_tdata[ROW_LSB +: INDEX_W];

   // sizes in use: zero acts as one, clamped to the store
   assign lx = (width_ff == '0) ? CSR_W'(1) :
               ((32'(width_ff) > MAX_WIDTH) ? CSR_W'(MAX_WIDTH) : width_ff);
   assign ly = (height_ff == '0) ? CSR_W'(1) :
               ((32'(height_ff) > MAX_HEIGHT) ? CSR_W'(MAX_HEIGHT) : height_ff);

   always_comb begin
      sx    = KS'(cx) + HALF;
      sy    = KS'(cy) + HALF;
      kx    = sx[KS-1:FRAC_BITS];
      ky    = sy[KS-1:FRAC_BITS];
      lowx  = (kx == '0);
      lowy  = (ky == '0);
      highx = (kx >= lx);
      highy = (ky >= ly);
      oor_in = (cx > {lx, {FRAC_BITS{1'b0}}}) || (cy > {ly, {FRAC_BITS{1'b0}}});

      // half cell next to a wall: the weight runs at twice the rate
      if (lowx) begin
         wx_in = WW'(cx) << 1;
      end else if (highx) begin
         wx_in = WW'(sx - {lx, {FRAC_BITS{1'b0}}}) << 1;
      end else begin
         wx_in = WW'(sx[FRAC_BITS-1:0]);
      end
      if (lowy) begin
         wy_in = WW'(cy) << 1;
      end else if (highy) begin
         wy_in = WW'(sy - {ly, {FRAC_BITS{1'b0}}}) << 1;
      end else begin
         wy_in = WW'(sy[FRAC_BITS-1:0]);
      end

      c0_in = lowx ? '0 : CB'(kx - 1'b1);
      c1_in = highx ? CB'(lx - 1'b1) : CB'(kx);
      r0_in = lowy ? '0 : RB'(ky - 1'b1);
      r1_in = highy ? RB'(ly - 1'b1) : RB'(ky);

      // normal component vanishes on the wall; corner order is {row, col}
      if (req_tuser[COMP_BIT] == COMP_X) begin
         zero_in = {highx, lowx, highx, lowx};
      end else begin
         zero_in = {highy, highy, lowy, lowy};
      end
   end

   // sample store
   assign mem_we  = accept && !is_query &&
                    (32'(wr_col) < MAX_WIDTH) && (32'(wr_row) < MAX_HEIGHT);
   assign wr_addr = {req_tuser[COMP_BIT], RB'(wr_row), CB'(wr_col)};
   assign rd_addr = {comp_ff, corner_ff[1] ? r1_ff : r0_ff, corner_ff[0] ? c1_ff : c0_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_ff[wr_addr] <= req_tdata[VAL_LSB +: SAMPLE_W];
      end
      rd_data_ff <= grid_ff[rd_addr];
   end

   // shared multiply-accumulate
   assign mac_sample = zero_ff[corner_ff] ? '0 : $signed(rd_data_ff);

   always_comb begin
      mac_ctrl = '{mul_en: 1'b0, src: SRC_SAMPLE, a_op: ACC_A_HOLD, t_op: ACC_T_HOLD};
      if (state_ff == ST_MULX) begin
         mac_weight = corner_ff[0] ? wx_ff : ONE - wx_ff;
      end else begin
         mac_weight = corner_ff[1] ? wy_ff : ONE - wy_ff;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               mac_ctrl.t_op = ACC_T_INIT;
            end
         end
         ST_MULX: begin
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.src    = SRC_SAMPLE;
         end
         ST_ACCX: mac_ctrl.a_op = corner_ff[0] ? ACC_A_ADD : ACC_A_LOAD;
         ST_MYL: begin
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.src    = SRC_ACC_LO;
         end
         ST_AYL: mac_ctrl.t_op = ACC_T_ADD_LO;
         ST_MYH: begin
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.src    = SRC_ACC_HI;
         end
         ST_AYH: mac_ctrl.t_op = ACC_T_ADD_HI;
         default: ;
      endcase
   end

   sgbi_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .ctrl      (mac_ctrl),
      .weight    (mac_weight),
      .sample    (mac_sample),
      .acc_total (acc_total)
   );

   // round-half-up already folded in; drop the fraction and saturate
   assign res_full = acc_total >>> (2 * FRAC_BITS);
   assign res_hi   = res_full[HW-1:31];

   always_comb begin
      if ((&res_hi) || !(|res_hi)) begin
         res_sat = res_full[31:0];
      end else if (res_hi[HW-32]) begin
         res_sat = SAT_MIN;
      end else begin
         res_sat = SAT_MAX;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      corner_in    = corner_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_oor_in   = rsp_oor_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               state_in = oor_in ? ST_FIN : ST_RD;
            end
         end
         ST_RD:   state_in = ST_MULX;
         ST_MULX: state_in = ST_ACCX;
         ST_ACCX: begin
            if (corner_ff[0]) begin
               state_in = ST_MYL;
            end else begin
               corner_in = corner_ff + 2'd1;
               state_in  = ST_RD;
            end
         end
         ST_MYL: state_in = ST_AYL;
         ST_AYL: state_in = ST_MYH;
         ST_MYH: state_in = ST_AYH;
         ST_AYH: begin
            corner_in = corner_ff + 2'd1;
            state_in  = corner_ff[1] ? ST_FIN : ST_RD;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = oor_ff ? '0 : res_sat;
               rsp_oor_in   = oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= GRID_SIZE_RESET;
         height_ff    <= GRID_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            case (csr_index)
               CSR_GRID_WIDTH:  width_ff  <= csr_wdata;
               CSR_GRID_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      rsp_data_ff <= rsp_data_in;
      rsp_oor_ff  <= rsp_oor_in;
      if (accept && is_query) begin
         comp_ff <= req_tuser[COMP_BIT];
         oor_ff  <= oor_in;
         wx_ff   <= wx_in;
         wy_ff   <= wy_in;
         c0_ff   <= c0_in;
         c1_ff   <= c1_in;
         r0_ff   <= r0_in;
         r1_ff   <= r1_in;
         zero_ff <= zero_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_oor_ff;

`ifndef SYNTH
   a_idle_corner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (corner_ff == 2'd0))
      else $error("corner counter not rewound at idle");

   a_fin_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && out_free) |=> (rsp_tvalid && state_ff == ST_IDLE))
      else $error("finished query did not reach the output register");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("out-of-range response carries a nonzero value");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_query && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("write transaction produced a response");
`endif

endmodule
